[rtl/iset_pkg.sv]
// Shared types and constants for the insertion-ordered integer set.
`timescale 1ns / 1ps

package iset_pkg;

  localparam int unsigned MaxValue = 1023;
  localparam int unsigned Slots    = MaxValue + 1;
  localparam int unsigned ValW     = $clog2(Slots);
  localparam int unsigned LinkW    = ValW + 1;
  localparam int unsigned CountW   = LinkW;

  // A link equal to the slot count marks the end of the list.
  localparam logic [LinkW-1:0] NullLink = LinkW'(Slots);

  typedef enum logic [1:0] {
    CmdContains = 2'd0,
    CmdInsert   = 2'd1,
    CmdRemove   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatPresent = 2'd1,
    StatAbsent  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StateClear,
    StateIdle,
    StateExec,
    StateFix
  } state_e;

  typedef struct packed {
    logic            en;
    logic [ValW-1:0] addr;
  } rd_t;

  // Entry of the prev memory: member bit on top of the prev link.
  typedef struct packed {
    logic            we;
    logic [ValW-1:0] addr;
    logic [LinkW:0]  data;
  } pm_wr_t;

  typedef struct packed {
    logic             we;
    logic [ValW-1:0]  addr;
    logic [LinkW-1:0] data;
  } nm_wr_t;

  typedef struct packed {
    logic              was_member;
    status_e           status;
    logic [CountW-1:0] member_count;
    logic              has_prev;
    logic [ValW-1:0]   prev_value;
    logic              has_next;
    logic [ValW-1:0]   next_value;
  } res_t;

endpackage

[rtl/insertion_ordered_int_set.sv]
// Top level of the insertion-ordered integer set: two link memories and the sequencer.
// Flow: a request is read in Idle and executed in Exec, where the result is registered once
// the output is free; one request is taken at a time, and a remove of a member that is not the tail
// also passes through a fix state, since the prev memory has one write port and needs two writes.
// Reset: member bits are swept to zero, one entry a cycle, with ready low.
`timescale 1ns / 1ps

module insertion_ordered_int_set import iset_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [ValW-1:0]   value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              was_member_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] member_count_o,
  output logic              has_prev_o,
  output logic [ValW-1:0]   prev_value_o,
  output logic              has_next_o,
  output logic [ValW-1:0]   next_value_o
);

  rd_t              rd;
  pm_wr_t           pm_wr;
  nm_wr_t           nm_wr;
  logic [LinkW:0]   pm_rdata;
  logic [LinkW-1:0] nm_rdata;
  res_t             res;

  iset_ram #(
    .Width(LinkW + 1),
    .AddrW(ValW)
  ) u_prev_mem (
    .clk_i  (clk_i),
    .we_i   (pm_wr.we),
    .waddr_i(pm_wr.addr),
    .wdata_i(pm_wr.data),
    .re_i   (rd.en),
    .raddr_i(rd.addr),
    .rdata_o(pm_rdata)
  );

  iset_ram #(
    .Width(LinkW),
    .AddrW(ValW)
  ) u_next_mem (
    .clk_i  (clk_i),
    .we_i   (nm_wr.we),
    .waddr_i(nm_wr.addr),
    .wdata_i(nm_wr.data),
    .re_i   (rd.en),
    .raddr_i(rd.addr),
    .rdata_o(nm_rdata)
  );

  iset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .pm_rdata_i (pm_rdata),
    .nm_rdata_i (nm_rdata),
    .rd_o       (rd),
    .pm_wr_o    (pm_wr),
    .nm_wr_o    (nm_wr),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign was_member_o   = res.was_member;
  assign status_o       = res.status;
  assign member_count_o = res.member_count;
  assign has_prev_o     = res.has_prev;
  assign prev_value_o   = res.prev_value;
  assign has_next_o     = res.has_next;
  assign next_value_o   = res.next_value;

  // Only one request is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // The count can never exceed the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (member_count_o <= CountW'(Slots)))
    else $error("member count out of range");

  // A failed remove reports an absent element with no neighbors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatAbsent) |-> !was_member_o && !has_prev_o && !has_next_o)
    else $error("absent status with member or neighbors");

  // An insert of a present element implies it was a member.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatPresent) |-> was_member_o)
    else $error("present status without prior membership");

endmodule

[rtl/iset_ram.sv]
// Single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module iset_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrW;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/iset_ctrl.sv]
// Sequencer and datapath: read, update links and count, write back, register the result.
`timescale 1ns / 1ps

module iset_ctrl import iset_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [ValW-1:0]   value_i,
  input  logic [LinkW:0]    pm_rdata_i,
  input  logic [LinkW-1:0]  nm_rdata_i,
  output rd_t               rd_o,
  output pm_wr_t            pm_wr_o,
  output nm_wr_t            nm_wr_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              res_o
);

  state_e            state_q, state_d;
  logic [ValW-1:0]   clr_addr_q, clr_addr_d;
  cmd_e              cmd_q;
  logic [ValW-1:0]   val_q;
  logic [LinkW-1:0]  tail_q, tail_d;
  logic [CountW-1:0] count_q, count_d;
  logic [ValW-1:0]   fix_addr_q, fix_addr_d;
  logic [LinkW-1:0]  fix_prev_q, fix_prev_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              exec_go;
  logic              was;
  logic [LinkW-1:0]  prev_l, next_l;
  logic [LinkW-1:0]  p, n;
  status_e           status;
  logic [CountW-1:0] cnt;
  logic              ins_ok, rem_ok, need_fix;

  assign accept  = in_valid_i && in_ready_o;
  assign exec_go = (state_q == StateExec) && (!out_valid_q || out_ready_i);

  // The stored next link is only meaningful for a member that is not the tail.
  assign was    = pm_rdata_i[LinkW];
  assign prev_l = pm_rdata_i[LinkW-1:0];
  assign next_l = (LinkW'(val_q) == tail_q) ? NullLink : nm_rdata_i;

  always_comb begin
    p      = NullLink;
    n      = NullLink;
    status = StatOk;
    cnt    = count_q;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    unique case (cmd_q)
      CmdInsert: begin
        if (was) begin
          status = StatPresent;
          p      = prev_l;
          n      = next_l;
        end else begin
          ins_ok = 1'b1;
          p      = tail_q;
          cnt    = count_q + CountW'(1);
        end
      end
      CmdRemove: begin
        if (!was) begin
          status = StatAbsent;
        end else begin
          rem_ok = 1'b1;
          p      = prev_l;
          n      = next_l;
          cnt    = count_q - CountW'(1);
        end
      end
      default: begin
        if (was) begin
          p = prev_l;
          n = next_l;
        end
      end
    endcase
  end

  assign need_fix = rem_ok && (n != NullLink);

  always_comb begin
    res_d.was_member   = was;
    res_d.status       = status;
    res_d.member_count = cnt;
    res_d.has_prev     = (p != NullLink);
    res_d.prev_value   = (p != NullLink) ? p[ValW-1:0] : '0;
    res_d.has_next     = (n != NullLink);
    res_d.next_value   = (n != NullLink) ? n[ValW-1:0] : '0;
  end

  always_comb begin
    count_d    = count_q;
    tail_d     = tail_q;
    fix_addr_d = fix_addr_q;
    fix_prev_d = fix_prev_q;
    if (exec_go) begin
      count_d    = cnt;
      fix_addr_d = n[ValW-1:0];
      fix_prev_d = p;
      if (ins_ok) begin
        tail_d = LinkW'(val_q);
      end else if (rem_ok && (n == NullLink)) begin
        tail_d = p;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateClear: begin
        if (clr_addr_q == ValW'(MaxValue)) begin
          state_d = StateIdle;
        end
      end
      StateIdle: begin
        if (accept) begin
          state_d = StateExec;
        end
      end
      StateExec: begin
        if (exec_go) begin
          state_d = need_fix ? StateFix : StateIdle;
        end
      end
      StateFix: state_d = StateIdle;
      default:  state_d = StateIdle;
    endcase
  end

  // State outputs: handshake and memory ports.
  always_comb begin
    in_ready_o   = 1'b0;
    clr_addr_d   = clr_addr_q;
    rd_o.en      = 1'b0;
    rd_o.addr    = value_i;
    pm_wr_o.we   = 1'b0;
    pm_wr_o.addr = val_q;
    pm_wr_o.data = '0;
    nm_wr_o.we   = 1'b0;
    nm_wr_o.addr = p[ValW-1:0];
    nm_wr_o.data = n;
    unique case (state_q)
      StateClear: begin
        pm_wr_o.we   = 1'b1;
        pm_wr_o.addr = clr_addr_q;
        clr_addr_d   = clr_addr_q + ValW'(1);
      end
      StateIdle: begin
        in_ready_o = 1'b1;
        rd_o.en    = in_valid_i;
      end
      StateExec: begin
        if (exec_go && ins_ok) begin
          // Append: new entry points back at the old tail, old tail points forward.
          pm_wr_o.we   = 1'b1;
          pm_wr_o.data = {1'b1, tail_q};
          nm_wr_o.we   = (tail_q != NullLink);
          nm_wr_o.addr = tail_q[ValW-1:0];
          nm_wr_o.data = LinkW'(val_q);
        end else if (exec_go && rem_ok) begin
          pm_wr_o.we   = 1'b1;
          pm_wr_o.data = {1'b0, NullLink};
          nm_wr_o.we   = (p != NullLink);
        end
      end
      StateFix: begin
        // Second write of a remove: the successor points back at the predecessor.
        pm_wr_o.we   = 1'b1;
        pm_wr_o.addr = fix_addr_q;
        pm_wr_o.data = {1'b1, fix_prev_q};
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      clr_addr_q  <= '0;
      tail_q      <= NullLink;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= value_i;
    end
    if (exec_go) begin
      res_q <= res_d;
    end
    fix_addr_q <= fix_addr_d;
    fix_prev_q <= fix_prev_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[tb/sv/iset_checker.sv]
// Scoreboard for the insertion-ordered integer set: tracks the set and checks every result.
`timescale 1ns / 1ps

module iset_checker import iset_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        command_i,
  input  logic [ValW-1:0]   value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              was_member_i,
  input  logic [1:0]        status_i,
  input  logic [CountW-1:0] member_count_i,
  input  logic              has_prev_i,
  input  logic [ValW-1:0]   prev_value_i,
  input  logic              has_next_i,
  input  logic [ValW-1:0]   next_value_i,
  output int                errors_o,
  output int                outstanding_o
);

  // Shadow copy of the set: member bits, links in insertion order, tail and count.
  logic              member_q [Slots];
  logic [LinkW-1:0]  prev_q   [Slots];
  logic [LinkW-1:0]  next_q   [Slots];
  logic [LinkW-1:0]  tail_q;
  logic [CountW-1:0] count_q;

  res_t expected_results [$];
  int   mismatch_cnt;
  int   waiting_cnt;

  assign errors_o      = mismatch_cnt;
  assign outstanding_o = waiting_cnt;

  // Applies one request to the shadow set and returns the result it must produce.
  function automatic res_t apply_set_request(input logic [1:0] cmd, input logic [ValW-1:0] v);
    res_t             r;
    logic             was;
    logic [LinkW-1:0] p;
    logic [LinkW-1:0] n;
    was = member_q[v];
    p   = NullLink;
    n   = NullLink;
    r.status = StatOk;
    case (cmd)
      CmdInsert: begin
        if (was) begin
          r.status = StatPresent;
          p = prev_q[v];
          n = next_q[v];
        end else begin
          prev_q[v] = tail_q;
          next_q[v] = NullLink;
          if (tail_q != NullLink) next_q[tail_q[ValW-1:0]] = {1'b0, v};
          tail_q      = {1'b0, v};
          member_q[v] = 1'b1;
          count_q     = count_q + 1'b1;
          p = prev_q[v];
        end
      end
      CmdRemove: begin
        if (!was) begin
          r.status = StatAbsent;
        end else begin
          p = prev_q[v];
          n = next_q[v];
          if (p != NullLink) next_q[p[ValW-1:0]] = n;
          if (n != NullLink) prev_q[n[ValW-1:0]] = p;
          else tail_q = p;
          prev_q[v]   = NullLink;
          next_q[v]   = NullLink;
          member_q[v] = 1'b0;
          count_q     = count_q - 1'b1;
        end
      end
      default: begin
        // The spare command code behaves as contains.
        if (was) begin
          p = prev_q[v];
          n = next_q[v];
        end
      end
    endcase
    r.was_member   = was;
    r.member_count = count_q;
    r.has_prev     = (p != NullLink);
    r.prev_value   = (p != NullLink) ? p[ValW-1:0] : '0;
    r.has_next     = (n != NullLink);
    r.next_value   = (n != NullLink) ? n[ValW-1:0] : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        member_q[i] = 1'b0;
        prev_q[i]   = NullLink;
        next_q[i]   = NullLink;
      end
      tail_q  = NullLink;
      count_q = '0;
      expected_results.delete();
      waiting_cnt  = 0;
      mismatch_cnt = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_results = {expected_results, apply_set_request(command_i, value_i)};
      end
      if (out_valid_i && out_ready_i) begin
        got.was_member   = was_member_i;
        got.status       = status_e'(status_i);
        got.member_count = member_count_i;
        got.has_prev     = has_prev_i;
        got.prev_value   = prev_value_i;
        got.has_next     = has_next_i;
        got.next_value   = next_value_i;
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%t: result with no request outstanding: was=%0d st=%0d cnt=%0d",
                     $realtime, got.was_member, got.status, got.member_count);
          end
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.was_member !== want.was_member || got.status !== want.status ||
              got.member_count !== want.member_count || got.has_prev !== want.has_prev ||
              got.prev_value !== want.prev_value || got.has_next !== want.has_next ||
              got.next_value !== want.next_value) begin
            if (mismatch_cnt < 10) begin
              $display("%t: result mismatch", $realtime);
              $display("  expected was=%0d st=%0d cnt=%0d prev=%0d/%0d next=%0d/%0d",
                       want.was_member, want.status, want.member_count, want.has_prev,
                       want.prev_value, want.has_next, want.next_value);
              $display("  actual   was=%0d st=%0d cnt=%0d prev=%0d/%0d next=%0d/%0d",
                       got.was_member, got.status, got.member_count, got.has_prev,
                       got.prev_value, got.has_next, got.next_value);
            end
            mismatch_cnt++;
          end
        end
      end
      waiting_cnt = expected_results.size();
    end
  end

endmodule

[tb/sv/tb_insertion_ordered_int_set.sv]
// Testbench top for the insertion-ordered integer set: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module tb_insertion_ordered_int_set;
  import iset_pkg::*;

  localparam logic [1:0] CmdSpare   = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         PoolSize   = 12;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              req_valid     = 1'b0;
  logic              req_ready;
  logic [1:0]        req_command   = CmdContains;
  logic [ValW-1:0]   req_value     = '0;
  logic              res_valid;
  logic              res_ready     = 1'b0;
  logic              res_was_member;
  logic [1:0]        res_status;
  logic [CountW-1:0] res_count;
  logic              res_has_prev;
  logic [ValW-1:0]   res_prev;
  logic              res_has_next;
  logic [ValW-1:0]   res_next;

  int errors;
  int outstanding;
  int idle_pct = 28;
  int cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  insertion_ordered_int_set i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_ready_o     (req_ready),
    .command_i      (req_command),
    .value_i        (req_value),
    .out_valid_o    (res_valid),
    .out_ready_i    (res_ready),
    .was_member_o   (res_was_member),
    .status_o       (res_status),
    .member_count_o (res_count),
    .has_prev_o     (res_has_prev),
    .prev_value_o   (res_prev),
    .has_next_o     (res_has_next),
    .next_value_o   (res_next)
  );

  iset_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_ready_i     (req_ready),
    .command_i      (req_command),
    .value_i        (req_value),
    .out_valid_i    (res_valid),
    .out_ready_i    (res_ready),
    .was_member_i   (res_was_member),
    .status_i       (res_status),
    .member_count_i (res_count),
    .has_prev_i     (res_has_prev),
    .prev_value_i   (res_prev),
    .has_next_i     (res_has_next),
    .next_value_i   (res_next),
    .errors_o       (errors),
    .outstanding_o  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("insertion_ordered_int_set regression: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off once traffic is flowing so
  // that the block fills up and stops taking requests.
  int  results_seen = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;

  always @(posedge clk) begin
    if (res_valid && res_ready) results_seen++;
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 400) begin
      hold_done = 1'b1;
      hold_left = 200;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Offers one request and returns in the time step of the edge that accepts it.
  // Valid is only lowered when an idle cycle is chosen before the next request.
  task automatic offer_request(input logic [1:0] cmd, input logic [ValW-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_command <= cmd;
    req_value   <= val;
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic logic [1:0] pick_command(input int ins_pct, input int rem_pct,
                                              input int con_pct);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) return CmdInsert;
    if (r < ins_pct + rem_pct) return CmdRemove;
    if (r < ins_pct + rem_pct + con_pct) return CmdContains;
    return CmdSpare;
  endfunction

  logic [ValW-1:0] pool  [PoolSize];
  logic [ValW-1:0] order [Slots];

  initial begin : stimulus
    logic [ValW-1:0] v;
    logic [ValW-1:0] tmp;
    int              j;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty set, head, tail and middle links, duplicate insert, absent remove,
    // the spare command code, and extreme values.
    offer_request(CmdContains, 10'd0);
    offer_request(CmdRemove, 10'd1023);
    offer_request(CmdInsert, 10'd0);
    offer_request(CmdInsert, 10'd1023);
    offer_request(CmdInsert, 10'd512);
    offer_request(CmdContains, 10'd0);
    offer_request(CmdContains, 10'd1023);
    offer_request(CmdContains, 10'd512);
    offer_request(CmdInsert, 10'd1023);
    offer_request(CmdRemove, 10'd1023);
    offer_request(CmdContains, 10'd1023);
    offer_request(CmdSpare, 10'd0);
    offer_request(CmdSpare, 10'd1023);
    offer_request(CmdRemove, 10'd0);
    offer_request(CmdRemove, 10'd512);
    offer_request(CmdContains, 10'd512);
    offer_request(CmdInsert, 10'd341);
    offer_request(CmdInsert, 10'd682);
    offer_request(CmdInsert, 10'd1);
    offer_request(CmdRemove, 10'd682);
    offer_request(CmdRemove, 10'd1);
    offer_request(CmdRemove, 10'd341);
    offer_request(CmdRemove, 10'd341);

    // Churn on a small pool of values so inserts and removes keep hitting members.
    for (int i = 0; i < PoolSize; i++) pool[i] = ValW'($urandom_range(Slots - 1));
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(9) == 0) v = ValW'($urandom_range(Slots - 1));
      else v = pool[$urandom_range(PoolSize - 1)];
      offer_request(pick_command(45, 35, 16), v);
    end

    // Fill the set completely in a shuffled order, starting with a stretch of no idling.
    for (int i = 0; i < Slots; i++) order[i] = ValW'(i);
    for (int i = Slots - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    idle_pct = 0;
    for (int i = 0; i < Slots; i++) begin
      if (i == 300) idle_pct = 28;
      offer_request(CmdInsert, order[i]);
    end

    // Drain and refill at random from a full set.
    for (int i = 0; i < 250; i++) begin
      offer_request(pick_command(30, 50, 15), ValW'($urandom_range(Slots - 1)));
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("insertion_ordered_int_set regression: pass");
    end else begin
      $display("insertion_ordered_int_set regression: fail");
    end
    $finish;
  end

endmodule
